// ===== hdl/masked_box_mean_raster_smoother_core_assert.svh =====
// assertion macros used by the smoother back end rtl
`ifndef MASKED_BOX_MEAN_RASTER_SMOOTHER_CORE_ASSERT_SVH
`define MASKED_BOX_MEAN_RASTER_SMOOTHER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MBMS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MBMS_NEVER(lbl, cond, msg) `MBMS_ASSERT(lbl, !(cond), msg)
`else
`define MBMS_ASSERT(lbl, prop, msg)
`define MBMS_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hdl/mbms_pkg.sv =====
`default_nettype none
package mbms_pkg;
	localparam int MAX_COLUMNS = 1024;
	localparam int MAX_ROWS    = 4096;
	localparam int MAX_LOOK    = 7;
	localparam int STORE_DEPTH = 2 * (MAX_LOOK * MAX_COLUMNS + MAX_LOOK) + 1;
	localparam int AW          = $clog2(STORE_DEPTH);

	typedef logic [AW-1:0] addr_t;

	// one stored pixel: valid flag and q8.8 height
	typedef struct packed {
		logic               vld;
		logic signed [15:0] val;
	} word_t;

	typedef enum logic [1:0] {
		CFG_LOOK = 2'd0,
		CFG_ROWS = 2'd1,
		CFG_COLS = 2'd2
	} cfg_idx_t;
endpackage
`default_nettype wire

// ===== hdl/mbms_front.sv =====
`default_nettype none
module mbms_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_axis_tvalid,
	output logic                 s_axis_tready,
	input  wire logic [16:0]     pix_data,
	input  wire logic            req_type,
	output logic                 q_valid,
	output mbms_pkg::word_t      q_word,
	input  wire logic            q_pop
);
	mbms_pkg::word_t ent_q [2];
	logic            wp_q;
	logic            rp_q;
	logic [1:0]      cnt_q;
	logic            push;
	mbms_pkg::word_t word;

	// drains and no-data pixels both store an empty word
	always_comb begin
		word.vld = !req_type && pix_data[16];
		word.val = word.vld ? pix_data[15:0] : 16'sd0;
	end

	assign s_axis_tready = (cnt_q != 2'd2);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = (cnt_q != 2'd0);
	assign q_word        = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (q_pop) rp_q <= !rp_q;
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hdl/mbms_div.sv =====
`default_nettype none
module mbms_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [23:0] dividend,
	input  wire logic [7:0]         divisor,
	output logic                    done,
	output logic [15:0]             quotient
);
	logic        busy_q;
	logic        done_q;
	logic        neg_q;
	logic [22:0] mag_q;
	logic [7:0]  rem_q;
	logic [7:0]  den_q;
	logic [4:0]  step_q;
	logic [23:0] absval;
	logic [8:0]  trial;
	logic [8:0]  diff;
	logic        qbit;

	// restoring division, one quotient bit per cycle
	assign absval = dividend[23] ? (24'd0 - dividend) : dividend;
	assign trial  = {rem_q, mag_q[22]};
	assign diff   = trial - {1'b0, den_q};
	assign qbit   = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 5'd23;
			end else if (busy_q) begin
				step_q <= step_q - 5'd1;
				if (step_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[23];
			mag_q <= absval[22:0];
			rem_q <= 8'd0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[7:0] : trial[7:0];
			mag_q <= {mag_q[21:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (16'd0 - mag_q[15:0]) : mag_q[15:0];
endmodule
`default_nettype wire

// ===== hdl/mbms_back.sv =====
`default_nettype none
`include "masked_box_mean_raster_smoother_core_assert.svh"
module mbms_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [1:0]      cfg_index,
	input  wire logic [12:0]     cfg_data,
	input  wire logic            q_valid,
	input  wire mbms_pkg::word_t q_word,
	output logic                 q_pop,
	output logic                 m_axis_tvalid,
	input  wire logic            m_axis_tready,
	output logic [15:0]          m_axis_tdata,
	output logic                 m_axis_tuser,
	output logic                 m_axis_tlast
);
	localparam int AW = mbms_pkg::AW;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b00000001,
		ST_CHECK  = 8'b00000010,
		ST_CENTER = 8'b00000100,
		ST_SCAN   = 8'b00001000,
		ST_FLUSH  = 8'b00010000,
		ST_DIVGO  = 8'b00100000,
		ST_DIV    = 8'b01000000,
		ST_OUT    = 8'b10000000
	} st_t;

	function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [10:0] inc);
		logic [AW:0] s;
		s = {1'b0, a} + (AW+1)'(inc);
		if (s >= (AW+1)'(mbms_pkg::STORE_DEPTH)) s = s - (AW+1)'(mbms_pkg::STORE_DEPTH);
		return s[AW-1:0];
	endfunction

	mbms_pkg::word_t mem [mbms_pkg::STORE_DEPTH];
	mbms_pkg::word_t rd_data_q;

	st_t             st_q;
	logic [2:0]      look_q;
	logic [12:0]     rows_q;
	logic [10:0]     cols_q;
	logic [22:0]     total_q;
	logic [12:0]     lag_q;
	logic [22:0]     in_pos_q;
	logic [22:0]     out_pos_q;
	logic [AW-1:0]   in_addr_q;
	logic [AW-1:0]   out_addr_q;
	logic [11:0]     row_q;
	logic [9:0]      col_q;
	logic [AW-1:0]   off_q;
	logic [3:0]      hm1_q;
	logic [3:0]      wm1_q;
	logic [3:0]      ri_q;
	logic [3:0]      ci_q;
	logic [AW-1:0]   row_addr_q;
	logic [AW-1:0]   col_addr_q;
	logic            acc_s1;
	logic signed [23:0] sum_q;
	logic [7:0]      cnt_q;
	logic [15:0]     res_val_q;
	logic            res_vld_q;
	logic            m_vld_q;
	logic [15:0]     m_data_q;
	logic            m_user_q;
	logic            m_last_q;

	logic [12:0]     eff_rows;
	logic [10:0]     eff_cols;
	logic [23:0]     prod;
	logic [13:0]     lagp;
	logic [23:0]     thr;
	logic            emit;
	logic [2:0]      a_up;
	logic [2:0]      b_left;
	logic [12:0]     rrem;
	logic [10:0]     crem;
	logic [2:0]      h_dn;
	logic [2:0]      w_rt;
	logic [13:0]     offp;
	logic [AW:0]     start_wide;
	logic [AW-1:0]   start_addr;
	logic            mem_we;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic            div_start;
	logic            div_done;
	logic [15:0]     div_quo;
	logic            out_load;
	logic            last_pos;
	logic            cfg_wr;
	logic            cfg_hit;

	// clamped frame geometry
	always_comb begin
		if (rows_q == 13'd0) eff_rows = 13'd1;
		else if (rows_q > 13'(mbms_pkg::MAX_ROWS)) eff_rows = 13'(mbms_pkg::MAX_ROWS);
		else eff_rows = rows_q;
		if (cols_q == 11'd0) eff_cols = 11'd1;
		else if (cols_q > 11'(mbms_pkg::MAX_COLUMNS)) eff_cols = 11'(mbms_pkg::MAX_COLUMNS);
		else eff_cols = cols_q;
	end
	assign prod = 24'(eff_rows) * 24'(eff_cols);
	assign lagp = 14'(look_q) * 14'(eff_cols) + 14'(look_q);

	// emit test and window extents for the current output position
	assign thr    = {1'b0, out_pos_q} + 24'(lag_q);
	assign emit   = (in_pos_q == total_q) || ({1'b0, in_pos_q} > thr);
	assign a_up   = (row_q > 12'(look_q)) ? look_q : row_q[2:0];
	assign b_left = (col_q > 10'(look_q)) ? look_q : col_q[2:0];
	assign rrem   = eff_rows - 13'd1 - {1'b0, row_q};
	assign crem   = eff_cols - 11'd1 - {1'b0, col_q};
	assign h_dn   = (rrem > 13'(look_q)) ? look_q : rrem[2:0];
	assign w_rt   = (crem > 11'(look_q)) ? look_q : crem[2:0];
	assign offp   = 14'(a_up) * 14'(eff_cols) + 14'(b_left);

	assign start_wide = (out_addr_q >= off_q)
		? {1'b0, out_addr_q} - {1'b0, off_q}
		: {1'b0, out_addr_q} + (AW+1)'(mbms_pkg::STORE_DEPTH) - {1'b0, off_q};
	assign start_addr = start_wide[AW-1:0];

	assign q_pop     = (st_q == ST_IDLE) && q_valid;
	assign mem_we    = q_pop && (in_pos_q < total_q);
	assign rd_en     = ((st_q == ST_CHECK) && emit) || (st_q == ST_SCAN);
	assign rd_addr   = (st_q == ST_SCAN) ? col_addr_q : out_addr_q;
	assign div_start = (st_q == ST_DIVGO);
	assign out_load  = (st_q == ST_OUT) && (!m_vld_q || m_axis_tready);
	assign last_pos  = (out_pos_q == total_q - 23'd1);
	// registers change only while the engine sits idle with nothing queued
	assign cfg_ready = (st_q == ST_IDLE) && !q_valid;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign cfg_hit   = cfg_wr && ((cfg_index == mbms_pkg::CFG_LOOK)
		|| (cfg_index == mbms_pkg::CFG_ROWS) || (cfg_index == mbms_pkg::CFG_COLS));

	always_ff @(posedge clk) begin
		if (mem_we) mem[in_addr_q] <= q_word;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	mbms_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			look_q     <= 3'd1;
			rows_q     <= 13'd1024;
			cols_q     <= 11'd1024;
			total_q    <= 23'd1048576;
			lag_q      <= 13'd1025;
			in_pos_q   <= '0;
			out_pos_q  <= '0;
			in_addr_q  <= '0;
			out_addr_q <= '0;
			row_q      <= '0;
			col_q      <= '0;
			acc_s1     <= 1'b0;
			m_vld_q    <= 1'b0;
		end else begin
			total_q <= prod[22:0];
			lag_q   <= lagp[12:0];
			acc_s1  <= 1'b0;
			if (m_vld_q && m_axis_tready && !out_load) m_vld_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (in_pos_q < total_q) begin
							in_pos_q  <= in_pos_q + 23'd1;
							in_addr_q <= wrap_add(in_addr_q, 11'd1);
						end
						st_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (emit) begin
						off_q <= offp[AW-1:0];
						hm1_q <= 4'(a_up) + 4'(h_dn);
						wm1_q <= 4'(b_left) + 4'(w_rt);
						st_q  <= ST_CENTER;
					end else begin
						st_q <= ST_IDLE;
					end
				end
				ST_CENTER: begin
					if (rd_data_q.vld) begin
						row_addr_q <= start_addr;
						col_addr_q <= start_addr;
						ri_q       <= 4'd0;
						ci_q       <= 4'd0;
						st_q       <= ST_SCAN;
					end else begin
						res_val_q <= 16'd0;
						res_vld_q <= 1'b0;
						st_q      <= ST_OUT;
					end
				end
				ST_SCAN: begin
					acc_s1 <= 1'b1;
					if (ci_q == wm1_q) begin
						if (ri_q == hm1_q) begin
							st_q <= ST_FLUSH;
						end else begin
							ri_q       <= ri_q + 4'd1;
							ci_q       <= 4'd0;
							row_addr_q <= wrap_add(row_addr_q, eff_cols);
							col_addr_q <= wrap_add(row_addr_q, eff_cols);
						end
					end else begin
						ci_q       <= ci_q + 4'd1;
						col_addr_q <= wrap_add(col_addr_q, 11'd1);
					end
				end
				ST_FLUSH: st_q <= ST_DIVGO;
				ST_DIVGO: st_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						res_val_q <= div_quo;
						res_vld_q <= 1'b1;
						st_q      <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						m_vld_q  <= 1'b1;
						m_data_q <= res_val_q;
						m_user_q <= res_vld_q;
						m_last_q <= last_pos;
						if (last_pos) begin
							out_pos_q  <= '0;
							in_pos_q   <= '0;
							out_addr_q <= '0;
							in_addr_q  <= '0;
							row_q      <= '0;
							col_q      <= '0;
						end else begin
							out_pos_q  <= out_pos_q + 23'd1;
							out_addr_q <= wrap_add(out_addr_q, 11'd1);
							if ({1'b0, col_q} == eff_cols - 11'd1) begin
								col_q <= '0;
								row_q <= row_q + 12'd1;
							end else begin
								col_q <= col_q + 10'd1;
							end
						end
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			if (cfg_wr) begin
				case (cfg_index)
					mbms_pkg::CFG_LOOK: look_q <= cfg_data[2:0];
					mbms_pkg::CFG_ROWS: rows_q <= cfg_data;
					mbms_pkg::CFG_COLS: cols_q <= cfg_data[10:0];
					default: ;
				endcase
			end
			if (cfg_hit) begin
				in_pos_q   <= '0;
				out_pos_q  <= '0;
				in_addr_q  <= '0;
				out_addr_q <= '0;
				row_q      <= '0;
				col_q      <= '0;
			end
		end
	end

	// window accumulation follows the registered memory read
	always_ff @(posedge clk) begin
		if (st_q == ST_CENTER) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (acc_s1 && rd_data_q.vld) begin
			sum_q <= sum_q + 24'(rd_data_q.val);
			cnt_q <= cnt_q + 8'd1;
		end
	end

	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tlast  = m_last_q;

	`MBMS_NEVER(a_in_pos_range, in_pos_q > total_q, "input position beyond frame")
	`MBMS_ASSERT(a_acc_from_scan, acc_s1 |-> $past(st_q == ST_SCAN), "accumulate outside scan")
	`MBMS_ASSERT(a_out_no_clobber, out_load |-> (!m_vld_q || m_axis_tready), "result overwritten")
	`MBMS_ASSERT(a_div_count, (st_q == ST_DIV && div_done) |-> (cnt_q != 8'd0), "zero count")
endmodule
`default_nettype wire

// ===== hdl/masked_box_mean_raster_smoother_core.sv =====
// channel   direction  contents
// s_axis    in         tdata: pixel_value, pixel_valid; tuser: req_type
// m_axis    out        tdata: smoothed_value; tuser: smoothed_valid; tlast: frame_last
// cfg       in         cfg_index selects look_distance, row_count, column_count
//
// an item that yields no result passes only the idle and check states of the back end
// a result with a no-data center skips the window scan and the divider; for one with a valid
//   center the window is read one word per cycle from the line store, then a
//   23-step bit-serial divider forms the mean
// reset clears positions and config to defaults; store contents are kept undefined
// a two-entry queue lets the input side take up to two more transactions while results stall
`default_nettype none
module masked_box_mean_raster_smoother_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // [15:0] pixel_value, [16] pixel_valid, rest zero
	input  wire logic        s_axis_tuser,  // [0] req_type
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // [15:0] smoothed_value
	output logic             m_axis_tuser,  // [0] smoothed_valid
	output logic             m_axis_tlast,  // frame_last
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [12:0] cfg_data
);
	// queue between the front classifier and the back window engine
	logic            q_valid;
	logic            q_pop;
	mbms_pkg::word_t q_word;

	mbms_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.pix_data      (s_axis_tdata[16:0]),
		.req_type      (s_axis_tuser),
		.q_valid       (q_valid),
		.q_word        (q_word),
		.q_pop         (q_pop)
	);

	// back end: line store, window scan, divider, output register
	mbms_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.q_valid       (q_valid),
		.q_word        (q_word),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);
endmodule
`default_nettype wire
